// ----- rtl/core/imu_kf_pkg.sv -----
// Shared constants, types and saturation helpers for the IMU angle Kalman filter.
`timescale 1ns / 1ps

package imu_kf_pkg;

    // Field and state widths
    localparam int DATA_W      = 32;   // angle, bias, rate: signed Q16.16
    localparam int DT_W        = 24;   // sample period: unsigned Q0.24
    localparam int NOISE_W     = 47;   // noise terms: unsigned Q15.32
    localparam int P_W         = 48;   // covariance: signed Q16.32
    localparam int K_W         = 48;   // gains: signed Q16.32
    localparam int DEN_W       = P_W + 1;   // innovation variance
    localparam int ERR_W       = DATA_W + 1;
    localparam int FRAC_DT     = 24;
    localparam int FRAC_P      = 32;

    // Shared multiplier: signed operands, magnitude multiply one digit of b per cycle
    localparam int OPND_W      = 50;
    localparam int MUL_DIGIT_W = 17;
    localparam int MUL_DIGITS  = 3;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
    localparam int MUL_B_W     = MUL_DIGIT_W * MUL_DIGITS;
    localparam int MUL_ACC_W   = OPND_W + MUL_B_W;
    localparam int MUL_RES_W   = 64;
    localparam int SUM_W       = MUL_RES_W + 1;

    // Gain divider: integer bits of a gain, quotient bits, restoring steps
    localparam int DIV_INT_W   = P_W - 1 - FRAC_P;
    localparam int QUO_W       = P_W - 1;
    localparam int DIV_STEPS   = QUO_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic signed [SUM_W-1:0] W_MAX_X = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] W_MIN_X = -W_MAX_X - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] P_MAX_X = SUM_W'((64'sd1 <<< (P_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] P_MIN_X = -P_MAX_X - SUM_W'(1);

    typedef struct packed {
        logic                     start;
        logic                     frac32;   // 1: scale by 2^-32, 0: by 2^-24
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [MUL_RES_W-1:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic                    start;
        logic signed [P_W-1:0]   num0;
        logic signed [P_W-1:0]   num1;
        logic signed [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic signed [K_W-1:0] k0;
        logic signed [K_W-1:0] k1;
    } div_rsp_t;

    // Clamp to the signed data width
    function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > W_MAX_X) r = W_MAX_X[DATA_W-1:0];
        else if (v < W_MIN_X) r = W_MIN_X[DATA_W-1:0];
        else r = v[DATA_W-1:0];
        return r;
    endfunction

    // Clamp to the signed covariance width
    function automatic logic signed [P_W-1:0] sat_p(input logic signed [SUM_W-1:0] v);
        logic signed [P_W-1:0] r;
        if (v > P_MAX_X) r = P_MAX_X[P_W-1:0];
        else if (v < P_MIN_X) r = P_MIN_X[P_W-1:0];
        else r = v[P_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/imu_kf_mul.sv -----
// Shared multi-cycle fixed-point multiplier with round-half-away rescaling.
`timescale 1ns / 1ps

module imu_kf_mul
    import imu_kf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam logic [MUL_CNT_W-1:0] LAST_DIGIT = MUL_CNT_W'(MUL_DIGITS - 1);

    logic                           busy_reg;
    logic                           rnd_reg;
    logic                           done_reg;
    logic [MUL_CNT_W-1:0]           cnt_reg;
    logic [OPND_W-1:0]              a_mag_reg;
    logic [MUL_B_W-1:0]             b_mag_reg;
    logic                           neg_reg;
    logic                           frac32_reg;
    logic [MUL_ACC_W-1:0]           acc_reg;
    logic signed [MUL_RES_W-1:0]    result_reg;

    logic [OPND_W-1:0]              a_abs;
    logic [OPND_W-1:0]              b_abs;
    logic [MUL_DIGIT_W-1:0]         digit;
    logic [OPND_W+MUL_DIGIT_W-1:0]  prod;
    logic [MUL_ACC_W-1:0]           acc_next;
    logic [MUL_ACC_W-1:0]           rnd_sum;
    logic [MUL_ACC_W-1:0]           rnd_shift;
    logic [MUL_RES_W-1:0]           mag;

    // Operand magnitudes
    assign a_abs = req.a[OPND_W-1] ? (~req.a + 1'b1) : req.a;
    assign b_abs = req.b[OPND_W-1] ? (~req.b + 1'b1) : req.b;

    // One digit of b per cycle, most significant first
    assign digit    = b_mag_reg[MUL_B_W-1 -: MUL_DIGIT_W];
    assign prod     = a_mag_reg * digit;
    assign acc_next = {acc_reg[MUL_ACC_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                    + {{(MUL_ACC_W-OPND_W-MUL_DIGIT_W){1'b0}}, prod};

    // Round to nearest, ties away from zero, then restore the sign
    always_comb begin
        if (frac32_reg) begin
            rnd_sum   = acc_reg + (MUL_ACC_W'(1) << (FRAC_P - 1));
            rnd_shift = rnd_sum >> FRAC_P;
        end else begin
            rnd_sum   = acc_reg + (MUL_ACC_W'(1) << (FRAC_DT - 1));
            rnd_shift = rnd_sum >> FRAC_DT;
        end
        mag = rnd_shift[MUL_RES_W-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= 1'b0;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIGIT) begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b1;
                end
            end else if (rnd_reg) begin
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_mag_reg  <= a_abs;
            b_mag_reg  <= {{(MUL_B_W-OPND_W){1'b0}}, b_abs};
            neg_reg    <= req.a[OPND_W-1] ^ req.b[OPND_W-1];
            frac32_reg <= req.frac32;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            acc_reg   <= acc_next;
            b_mag_reg <= b_mag_reg << MUL_DIGIT_W;
        end
        if (rnd_reg) begin
            result_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

// ----- rtl/core/imu_kf_div.sv -----
// Two-lane restoring divider for the Kalman gains (shared divisor, truncating).
`timescale 1ns / 1ps

module imu_kf_div
    import imu_kf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_PREP = 2'd1;
    localparam logic [1:0] DV_RUN  = 2'd2;
    localparam logic [1:0] DV_FIN  = 2'd3;

    localparam int REM_W = DEN_W + 1;
    localparam int CMP_W = DEN_W + DIV_INT_W;
    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);
    localparam logic [QUO_W-1:0]     Q_SAT     = {QUO_W{1'b1}};

    logic [1:0]              state_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [DEN_W-1:0]        den_mag_reg;
    logic                    zero_reg;
    logic [P_W-1:0]          num_mag_reg [2];
    logic                    neg_reg     [2];
    logic                    sat_reg     [2];
    logic [REM_W-1:0]        rem_reg     [2];
    logic [QUO_W-1:0]        nsh_reg     [2];
    logic [QUO_W-1:0]        quo_reg     [2];
    logic signed [K_W-1:0]   k_reg       [2];

    logic [P_W-1:0]          num_abs [2];
    logic [DEN_W-1:0]        den_abs;
    logic [REM_W-1:0]        trial   [2];
    logic                    ge      [2];
    logic [QUO_W-1:0]        k_mag   [2];

    assign den_abs    = req.den[DEN_W-1] ? (~req.den + 1'b1) : req.den;
    assign num_abs[0] = req.num0[P_W-1] ? (~req.num0 + 1'b1) : req.num0;
    assign num_abs[1] = req.num1[P_W-1] ? (~req.num1 + 1'b1) : req.num1;

    // One restoring step per lane
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            trial[i] = {rem_reg[i][REM_W-2:0], nsh_reg[i][QUO_W-1]};
            ge[i]    = trial[i] >= {1'b0, den_mag_reg};
            k_mag[i] = zero_reg ? '0 : (sat_reg[i] ? Q_SAT : quo_reg[i]);
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                DV_IDLE: begin
                    if (req.start) state_reg <= DV_PREP;
                end
                DV_PREP: begin
                    cnt_reg   <= '0;
                    state_reg <= DV_RUN;
                end
                DV_RUN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) state_reg <= DV_FIN;
                end
                DV_FIN: begin
                    state_reg <= DV_IDLE;
                end
                default: begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    // Lane datapath
    always_ff @(posedge aclk) begin
        if (state_reg == DV_IDLE && req.start) begin
            den_mag_reg    <= den_abs;
            zero_reg       <= (req.den == '0);
            num_mag_reg[0] <= num_abs[0];
            num_mag_reg[1] <= num_abs[1];
            neg_reg[0]     <= req.num0[P_W-1] ^ req.den[DEN_W-1];
            neg_reg[1]     <= req.num1[P_W-1] ^ req.den[DEN_W-1];
        end
        for (int i = 0; i < 2; i++) begin
            case (state_reg)
                DV_PREP: begin
                    // integer part at or above 2^15 saturates the gain
                    sat_reg[i] <= {{(CMP_W-P_W){1'b0}}, num_mag_reg[i]}
                               >= {den_mag_reg, {DIV_INT_W{1'b0}}};
                    rem_reg[i] <= {{(REM_W-(P_W-DIV_INT_W)){1'b0}},
                                   num_mag_reg[i][P_W-1:DIV_INT_W]};
                    nsh_reg[i] <= {num_mag_reg[i][DIV_INT_W-1:0], {FRAC_P{1'b0}}};
                    quo_reg[i] <= '0;
                end
                DV_RUN: begin
                    rem_reg[i] <= ge[i] ? (trial[i] - {1'b0, den_mag_reg}) : trial[i];
                    quo_reg[i] <= {quo_reg[i][QUO_W-2:0], ge[i]};
                    nsh_reg[i] <= nsh_reg[i] << 1;
                end
                DV_FIN: begin
                    k_reg[i] <= neg_reg[i] ? -$signed({1'b0, k_mag[i]})
                                           : $signed({1'b0, k_mag[i]});
                end
                default: begin
                end
            endcase
        end
    end

    assign rsp.busy = (state_reg != DV_IDLE);
    assign rsp.k0   = k_reg[0];
    assign rsp.k1   = k_reg[1];

endmodule

// ----- rtl/core/imu_kf_top.sv -----
// One sample at a time: the next is accepted only after a 47-step gain divider and ten
//   passes of the shared multiplier (two of them overlapped with the divider) have run.
// A finished result waits in the output register while the next request is accepted.
// Reset (aresetn low, synchronous): registers to defaults, angle and bias to zero,
//   covariance to the identity; no clearing pass.
`timescale 1ns / 1ps

module imu_angle_kalman_filter_top
    import imu_kf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [NOISE_W-1:0]   cfg_wdata,
    // input samples
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*DATA_W-1:0]  s_tdata,   // [31:0] measured_angle, [63:32] measured_rate
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*DATA_W-1:0]  m_tdata    // [31:0] filtered_angle, [63:32] corrected_rate
);

    // Register indexes
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_ANGLE_NOISE   = 2'd1;
    localparam logic [1:0] CFG_BIAS_NOISE    = 2'd2;
    localparam logic [1:0] CFG_MEAS_NOISE    = 2'd3;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_DIVW  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // Multiplier passes, in issue order
    localparam logic [3:0] OP_P0    = 4'd0;  // P0 += (q_angle - P01 - P10) * dt
    localparam logic [3:0] OP_P12   = 4'd1;  // P01, P10 += -P11 * dt
    localparam logic [3:0] OP_ANG   = 4'd2;  // angle += (rate - bias) * dt
    localparam logic [3:0] OP_P3    = 4'd3;  // P11 += q_bias * dt
    localparam logic [3:0] OP_KANG  = 4'd4;  // angle += k0 * err
    localparam logic [3:0] OP_KBIAS = 4'd5;  // bias += k1 * err
    localparam logic [3:0] OP_C0    = 4'd6;  // P00 -= k0 * P00
    localparam logic [3:0] OP_C1    = 4'd7;  // P01 -= k0 * P01
    localparam logic [3:0] OP_C2    = 4'd8;  // P10 -= k1 * P00
    localparam logic [3:0] OP_C3    = 4'd9;  // P11 -= k1 * P01

    localparam logic signed [P_W-1:0] P_ONE = P_W'(1) << FRAC_P;

    logic [2:0]                 state_reg;
    logic [3:0]                 op_reg;

    logic [DT_W-1:0]            dt_reg;
    logic [NOISE_W-1:0]         q_angle_reg;
    logic [NOISE_W-1:0]         q_bias_reg;
    logic [NOISE_W-1:0]         r_meas_reg;

    logic signed [DATA_W-1:0]   angle_reg;
    logic signed [DATA_W-1:0]   bias_reg;
    logic signed [P_W-1:0]      p0_reg;
    logic signed [P_W-1:0]      p1_reg;
    logic signed [P_W-1:0]      p2_reg;
    logic signed [P_W-1:0]      p3_reg;

    logic signed [DATA_W-1:0]   meas_reg;
    logic signed [DATA_W-1:0]   gyro_reg;
    logic signed [P_W-1:0]      pc0_reg;
    logic signed [P_W-1:0]      t1_reg;
    logic signed [ERR_W-1:0]    err_reg;

    logic                       m_tvalid_reg;
    logic [2*DATA_W-1:0]        m_tdata_reg;

    mul_req_t                   mul_req;
    mul_rsp_t                   mul_rsp;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    logic signed [OPND_W-1:0]   opnd_a;
    logic signed [OPND_W-1:0]   opnd_b;
    logic                       frac32;
    logic signed [SUM_W-1:0]    rx;
    logic signed [SUM_W-1:0]    wb_base;
    logic                       wb_sub;
    logic signed [SUM_W-1:0]    wb_sum;
    logic signed [SUM_W-1:0]    p2_sum;
    logic signed [DATA_W-1:0]   rate;
    logic                       s_acc;
    logic                       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Operand selection for the shared multiplier
    always_comb begin
        opnd_a = '0;
        opnd_b = {{(OPND_W-DT_W){1'b0}}, dt_reg};
        frac32 = 1'b0;
        case (op_reg)
            OP_P0: begin
                opnd_a = {{(OPND_W-NOISE_W){1'b0}}, q_angle_reg}
                       - {{(OPND_W-P_W){p1_reg[P_W-1]}}, p1_reg}
                       - {{(OPND_W-P_W){p2_reg[P_W-1]}}, p2_reg};
            end
            OP_P12: begin
                opnd_a = -{{(OPND_W-P_W){p3_reg[P_W-1]}}, p3_reg};
            end
            OP_ANG: begin
                opnd_a = {{(OPND_W-DATA_W){gyro_reg[DATA_W-1]}}, gyro_reg}
                       - {{(OPND_W-DATA_W){bias_reg[DATA_W-1]}}, bias_reg};
            end
            OP_P3: begin
                opnd_a = {{(OPND_W-NOISE_W){1'b0}}, q_bias_reg};
            end
            OP_KANG, OP_KBIAS: begin
                opnd_a = (op_reg == OP_KANG)
                       ? {{(OPND_W-K_W){div_rsp.k0[K_W-1]}}, div_rsp.k0}
                       : {{(OPND_W-K_W){div_rsp.k1[K_W-1]}}, div_rsp.k1};
                opnd_b = {{(OPND_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                frac32 = 1'b1;
            end
            OP_C0, OP_C1, OP_C2, OP_C3: begin
                opnd_a = (op_reg == OP_C0 || op_reg == OP_C1)
                       ? {{(OPND_W-K_W){div_rsp.k0[K_W-1]}}, div_rsp.k0}
                       : {{(OPND_W-K_W){div_rsp.k1[K_W-1]}}, div_rsp.k1};
                opnd_b = (op_reg == OP_C0 || op_reg == OP_C2)
                       ? {{(OPND_W-P_W){pc0_reg[P_W-1]}}, pc0_reg}
                       : {{(OPND_W-P_W){t1_reg[P_W-1]}}, t1_reg};
                frac32 = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign mul_req.start  = (state_reg == ST_ISSUE);
    assign mul_req.frac32 = frac32;
    assign mul_req.a      = opnd_a;
    assign mul_req.b      = opnd_b;

    // Gains start once the predicted P00 and P10 are in place
    assign div_req.start = (state_reg == ST_ISSUE) && (op_reg == OP_ANG);
    assign div_req.num0  = p0_reg;
    assign div_req.num1  = p2_reg;
    assign div_req.den   = {{(DEN_W-NOISE_W){1'b0}}, r_meas_reg}
                         + {{(DEN_W-P_W){p0_reg[P_W-1]}}, p0_reg};

    // Writeback: target plus or minus the product, clamped at the register
    always_comb begin
        rx      = {mul_rsp.result[MUL_RES_W-1], mul_rsp.result};
        wb_base = {{(SUM_W-P_W){p0_reg[P_W-1]}}, p0_reg};
        wb_sub  = 1'b0;
        case (op_reg)
            OP_P0:    wb_base = {{(SUM_W-P_W){p0_reg[P_W-1]}}, p0_reg};
            OP_P12:   wb_base = {{(SUM_W-P_W){p1_reg[P_W-1]}}, p1_reg};
            OP_ANG:   wb_base = {{(SUM_W-DATA_W){angle_reg[DATA_W-1]}}, angle_reg};
            OP_P3:    wb_base = {{(SUM_W-P_W){p3_reg[P_W-1]}}, p3_reg};
            OP_KANG:  wb_base = {{(SUM_W-DATA_W){angle_reg[DATA_W-1]}}, angle_reg};
            OP_KBIAS: wb_base = {{(SUM_W-DATA_W){bias_reg[DATA_W-1]}}, bias_reg};
            OP_C0: begin
                wb_base = {{(SUM_W-P_W){p0_reg[P_W-1]}}, p0_reg};
                wb_sub  = 1'b1;
            end
            OP_C1: begin
                wb_base = {{(SUM_W-P_W){p1_reg[P_W-1]}}, p1_reg};
                wb_sub  = 1'b1;
            end
            OP_C2: begin
                wb_base = {{(SUM_W-P_W){p2_reg[P_W-1]}}, p2_reg};
                wb_sub  = 1'b1;
            end
            OP_C3: begin
                wb_base = {{(SUM_W-P_W){p3_reg[P_W-1]}}, p3_reg};
                wb_sub  = 1'b1;
            end
            default: begin
            end
        endcase
        wb_sum = wb_sub ? (wb_base - rx) : (wb_base + rx);
        p2_sum = {{(SUM_W-P_W){p2_reg[P_W-1]}}, p2_reg} + rx;
        rate   = sat_w({{(SUM_W-DATA_W){gyro_reg[DATA_W-1]}}, gyro_reg}
                     - {{(SUM_W-DATA_W){bias_reg[DATA_W-1]}}, bias_reg});
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg      <= DT_W'(83886);
            q_angle_reg <= NOISE_W'(42949673);
            q_bias_reg  <= NOISE_W'(429497);
            r_meas_reg  <= NOISE_W'(64'd42949672960);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SAMPLE_PERIOD: dt_reg      <= cfg_wdata[DT_W-1:0];
                CFG_ANGLE_NOISE:   q_angle_reg <= cfg_wdata;
                CFG_BIAS_NOISE:    q_bias_reg  <= cfg_wdata;
                CFG_MEAS_NOISE:    r_meas_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_P0;
            angle_reg <= '0;
            bias_reg  <= '0;
            p0_reg    <= P_ONE;
            p1_reg    <= '0;
            p2_reg    <= '0;
            p3_reg    <= P_ONE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        op_reg    <= OP_P0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_rsp.done) begin
                        case (op_reg)
                            OP_P0:    p0_reg    <= sat_p(wb_sum);
                            OP_P12: begin
                                p1_reg <= sat_p(wb_sum);
                                p2_reg <= sat_p(p2_sum);
                            end
                            OP_ANG:   angle_reg <= sat_w(wb_sum);
                            OP_P3:    p3_reg    <= sat_p(wb_sum);
                            OP_KANG:  angle_reg <= sat_w(wb_sum);
                            OP_KBIAS: bias_reg  <= sat_w(wb_sum);
                            OP_C0:    p0_reg    <= sat_p(wb_sum);
                            OP_C1:    p1_reg    <= sat_p(wb_sum);
                            OP_C2:    p2_reg    <= sat_p(wb_sum);
                            OP_C3:    p3_reg    <= sat_p(wb_sum);
                            default: begin
                            end
                        endcase
                        op_reg <= op_reg + 1'b1;
                        if (op_reg == OP_P3) state_reg <= ST_DIVW;
                        else if (op_reg == OP_C3) state_reg <= ST_FIN;
                        else state_reg <= ST_ISSUE;
                    end
                end
                ST_DIVW: begin
                    if (!div_rsp.busy) state_reg <= ST_ISSUE;
                end
                ST_FIN: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Sample latch and per-sample temporaries
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            meas_reg <= s_tdata[DATA_W-1:0];
            gyro_reg <= s_tdata[2*DATA_W-1:DATA_W];
        end
        if (div_req.start) begin
            pc0_reg <= p0_reg;
            t1_reg  <= p1_reg;
        end
        // angle prediction is already written back when P11 is issued
        if (state_reg == ST_ISSUE && op_reg == OP_P3) begin
            err_reg <= {meas_reg[DATA_W-1], meas_reg} - {angle_reg[DATA_W-1], angle_reg};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_tdata_reg <= {rate, angle_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    imu_kf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    imu_kf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the IMU angle Kalman filter: bit-exact predictor and scoreboard.
`timescale 1ns / 1ps

module testbench;
    import imu_kf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no request moving on either side
    localparam int RX_LONG_HOLD    = 1500;   // long receiver hold-off
    localparam int TAIL_CYCLES     = 300;    // settle time after the last result
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 100;

    localparam logic [DATA_W-1:0]  S_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  S_MIN  = 32'h8000_0000;
    localparam logic [DT_W-1:0]    DT_MAX = 24'hFF_FFFF;
    localparam logic [NOISE_W-1:0] N_MAX  = 47'h7FFF_FFFF_FFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SAMPLE_PERIOD,
        REG_ANGLE_NOISE,
        REG_BIAS_NOISE,
        REG_MEAS_NOISE
    } cfg_reg_e;

    // kinds of filter settings for a random phase
    typedef enum int {
        CFG_DEFAULT,
        CFG_REALISTIC,
        CFG_RANDOM,
        CFG_EXTREME
    } cfg_mode_e;

    typedef struct packed {
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] angle;
    } estimate_t;

    // Scoreboard: fixed-point angle/bias filter and the queue of estimates it predicts
    class angle_scoreboard;
        logic [DT_W-1:0]    period;
        logic [NOISE_W-1:0] q_angle;
        logic [NOISE_W-1:0] q_bias;
        logic [NOISE_W-1:0] r_meas;
        longint             angle_est;
        longint             bias_est;
        longint             cov [4];
        estimate_t          pending_estimates [$];
        int unsigned        errors;

        function new();
            period    = 24'd83886;
            q_angle   = 47'd42949673;
            q_bias    = 47'd429497;
            r_meas    = 47'd42949672960;
            angle_est = 0;
            bias_est  = 0;
            cov[0]    = longint'(1) <<< FRAC_P;
            cov[1]    = 0;
            cov[2]    = 0;
            cov[3]    = longint'(1) <<< FRAC_P;
            errors    = 0;
        endfunction

        function int pending();
            return pending_estimates.size();
        endfunction

        // clamp to a signed width of 'bits'
        function longint clamp_bits(logic signed [65:0] v, int unsigned bits);
            logic signed [65:0] hi;
            logic signed [65:0] lo;
            hi = (66'sd1 <<< (bits - 1)) - 66'sd1;
            lo = -hi - 66'sd1;
            if (v > hi) v = hi;
            else if (v < lo) v = lo;
            return v[63:0];
        endfunction

        function longint add_clamp(longint a, longint b, int unsigned bits);
            logic signed [65:0] s;
            s = a;
            s = s + b;
            return clamp_bits(s, bits);
        endfunction

        function longint sub_clamp(longint a, longint b, int unsigned bits);
            logic signed [65:0] s;
            s = a;
            s = s - b;
            return clamp_bits(s, bits);
        endfunction

        // a*b/2^sh, magnitude rounded half up (ties away from zero), saturated
        function longint round_mul(longint a, longint b, int unsigned sh);
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] prod;
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            prod = {64'd0, ua} * {64'd0, ub};
            prod = prod + (128'd1 << (sh - 1));
            prod = prod >> sh;
            if (prod > 128'h7FFF_FFFF_FFFF_FFFF) prod = 128'h7FFF_FFFF_FFFF_FFFF;
            return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        // gain num/den in Q16.32, truncated toward zero; zero divisor gives zero
        function longint gain_div(longint num, longint den);
            logic [63:0]  un;
            logic [63:0]  ud;
            logic [127:0] q;
            if (den == 0) return 0;
            un = (num < 0) ? -num : num;
            ud = (den < 0) ? -den : den;
            if (un / ud > 64'd32767) q = 128'h7FFF_FFFF_FFFF;
            else q = ({64'd0, un} << FRAC_P) / {64'd0, ud};
            return ((num < 0) != (den < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function void write_reg(cfg_reg_e idx, logic [NOISE_W-1:0] value);
            case (idx)
                REG_SAMPLE_PERIOD: period  = value[DT_W-1:0];
                REG_ANGLE_NOISE:   q_angle = value;
                REG_BIAS_NOISE:    q_bias  = value;
                REG_MEAS_NOISE:    r_meas  = value;
                default: ;
            endcase
        endfunction

        // one accepted sample: predict, propagate, correct, queue the estimate
        function void note_sample(logic [2*DATA_W-1:0] data);
            logic signed [DATA_W-1:0] m32;
            logic signed [DATA_W-1:0] g32;
            longint meas, gyro, dt, qa, qb, rm, pd0, e, k0, k1, pc0, pc1, t1, err, rate;
            estimate_t est;
            m32  = data[DATA_W-1:0];
            g32  = data[2*DATA_W-1:DATA_W];
            meas = m32;
            gyro = g32;
            dt   = period;
            qa   = q_angle;
            qb   = q_bias;
            rm   = r_meas;

            // predict angle from the bias-corrected rate
            angle_est = add_clamp(angle_est,
                round_mul(sub_clamp(gyro, bias_est, 64), dt, FRAC_DT), DATA_W);

            // propagate covariance; P01 and P10 use the old P11
            pd0    = qa - cov[1] - cov[2];
            cov[0] = add_clamp(cov[0], round_mul(pd0, dt, FRAC_DT), P_W);
            cov[1] = add_clamp(cov[1], round_mul(-cov[3], dt, FRAC_DT), P_W);
            cov[2] = add_clamp(cov[2], round_mul(-cov[3], dt, FRAC_DT), P_W);
            cov[3] = add_clamp(cov[3], round_mul(qb, dt, FRAC_DT), P_W);

            // gains
            pc0 = cov[0];
            pc1 = cov[2];
            e   = rm + pc0;
            k0  = gain_div(pc0, e);
            k1  = gain_div(pc1, e);

            // correct angle and bias
            err       = sub_clamp(meas, angle_est, 64);
            angle_est = add_clamp(angle_est, round_mul(k0, err, FRAC_P), DATA_W);
            bias_est  = add_clamp(bias_est, round_mul(k1, err, FRAC_P), DATA_W);
            rate      = sub_clamp(gyro, bias_est, DATA_W);

            // covariance update
            t1     = cov[1];
            cov[0] = sub_clamp(cov[0], round_mul(k0, pc0, FRAC_P), P_W);
            cov[1] = sub_clamp(cov[1], round_mul(k0, t1, FRAC_P), P_W);
            cov[2] = sub_clamp(cov[2], round_mul(k1, pc0, FRAC_P), P_W);
            cov[3] = sub_clamp(cov[3], round_mul(k1, t1, FRAC_P), P_W);

            est.angle = angle_est[DATA_W-1:0];
            est.rate  = rate[DATA_W-1:0];
            pending_estimates.push_back(est);
        endfunction

        function void check_estimate(logic [2*DATA_W-1:0] data);
            estimate_t want;
            if (pending_estimates.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time, data);
                errors++;
                return;
            end
            want = pending_estimates.pop_front();
            if (data[DATA_W-1:0] !== want.angle) begin
                $display("%0t: filtered_angle expected %h, actual %h",
                         $time, want.angle, data[DATA_W-1:0]);
                errors++;
            end
            if (data[2*DATA_W-1:DATA_W] !== want.rate) begin
                $display("%0t: corrected_rate expected %h, actual %h",
                         $time, want.rate, data[2*DATA_W-1:DATA_W]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = REG_SAMPLE_PERIOD;
    logic [NOISE_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [2*DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*DATA_W-1:0]   m_tdata;

    angle_scoreboard sb;
    bit              quiet       = 1'b0;   // no idling on either side
    bit              rx_hold_req = 1'b0;   // ask the receiver for a long hold-off
    int unsigned     tx_calm     = 0;      // samples left to send back to back
    int unsigned     stall_cycles = 0;
    logic [DT_W-1:0] cur_dt      = 24'd83886;

    // synthetic IMU motion: Q16.16 angle, rate and gyro offset
    longint sim_angle = 0;
    longint sim_rate  = 0;
    longint sim_bias  = 0;

    always #5 aclk = ~aclk;

    imu_angle_kalman_filter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Monitor: register writes, accepted requests and results at each edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.write_reg(cfg_reg_e'(cfg_index), cfg_wdata);
            if (m_tvalid && m_tready) sb.check_estimate(m_tdata);
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
        end
    end

    // Watchdog: nothing moving for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result sink: random stall bursts, long ready stretches, one long hold-off on request
    initial begin : result_sink
        int unsigned burst;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                burst = $urandom_range(1, 12);
                repeat (burst) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 16);
                repeat (burst) @(posedge aclk);
            end
        end
    end

    function automatic longint spread(int unsigned span);
        return longint'($urandom_range(0, 2 * span)) - longint'(span);
    endfunction

    function automatic logic [NOISE_W-1:0] rand47();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[NOISE_W-1:0];
    endfunction

    task automatic write_one(input cfg_reg_e idx, input logic [NOISE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Write all four registers; junk above bit 23 of the period must be dropped
    task automatic load_config(input logic [DT_W-1:0] dt, input logic [NOISE_W-1:0] qa,
                               input logic [NOISE_W-1:0] qb, input logic [NOISE_W-1:0] rm);
        logic [NOISE_W-1:0] dt_word;
        dt_word = rand47();
        dt_word[DT_W-1:0] = dt;
        write_one(REG_SAMPLE_PERIOD, dt_word);
        write_one(REG_ANGLE_NOISE, qa);
        write_one(REG_BIAS_NOISE, qb);
        write_one(REG_MEAS_NOISE, rm);
        cfg_we <= 1'b0;
        cur_dt = dt;
    endtask

    task automatic choose_config(input cfg_mode_e mode);
        logic [63:0] w;
        case (mode)
            CFG_DEFAULT: begin
                load_config(24'd83886, 47'd42949673, 47'd429497, 47'd42949672960);
            end
            CFG_REALISTIC: begin
                w = {32'd0, $urandom} << $urandom_range(0, 8);
                load_config(DT_W'($urandom_range(8000, 1700000)), {15'd0, $urandom},
                            47'($urandom_range(0, 1 << 24)), w[NOISE_W-1:0]);
            end
            CFG_RANDOM: begin
                load_config(DT_W'($urandom), rand47(), rand47(), rand47());
            end
            default: begin
                load_config($urandom_range(0, 1) ? DT_MAX : '0,
                            $urandom_range(0, 1) ? N_MAX : '0,
                            $urandom_range(0, 1) ? N_MAX : '0,
                            $urandom_range(0, 1) ? N_MAX : '0);
            end
        endcase
    endtask

    // Offer one request and hold it until accepted
    task automatic send_sample(input logic [DATA_W-1:0] ang, input logic [DATA_W-1:0] rt);
        int unsigned gap;
        if (tx_calm > 0) begin
            tx_calm--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            tx_calm = $urandom_range(10, 30);
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rt, ang};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_results_drained();
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Mostly plausible IMU motion; some full-range noise and some angle jumps
    task automatic next_stimulus(output logic [DATA_W-1:0] ang, output logic [DATA_W-1:0] rt);
        int unsigned pick;
        longint      dt_l;
        longint      a;
        longint      r;
        pick = $urandom_range(0, 9);
        dt_l = cur_dt;
        sim_rate = sim_rate + spread(131072);
        if (sim_rate > 32768000) sim_rate = 32768000;
        if (sim_rate < -32768000) sim_rate = -32768000;
        sim_angle = sim_angle + ((sim_rate * dt_l) >>> 24);
        if (sim_angle > (longint'(180) <<< 16)) begin
            sim_angle = longint'(180) <<< 16;
            sim_rate  = -sim_rate;
        end else if (sim_angle < -(longint'(180) <<< 16)) begin
            sim_angle = -(longint'(180) <<< 16);
            sim_rate  = -sim_rate;
        end
        a = sim_angle + spread(65536);
        r = sim_rate + sim_bias + spread(32768);
        if (pick == 0) begin
            a = longint'($urandom);
            r = longint'($urandom);
        end else if (pick == 1) begin
            a = spread(1 << 30);
        end
        ang = a[DATA_W-1:0];
        rt  = r[DATA_W-1:0];
    endtask

    // Stimulus
    initial begin : stimulus
        logic [DATA_W-1:0] ang;
        logic [DATA_W-1:0] rt;
        cfg_mode_e         plan [RANDOM_PHASES];
        sb = new();
        plan = '{CFG_REALISTIC, CFG_RANDOM, CFG_REALISTIC, CFG_EXTREME,
                 CFG_REALISTIC, CFG_DEFAULT, CFG_RANDOM, CFG_REALISTIC};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values written back explicitly, then field extremes
        load_config(24'd83886, 47'd42949673, 47'd429497, 47'd42949672960);
        send_sample('0, '0);
        send_sample(S_MAX, S_MAX);
        send_sample(S_MIN, S_MIN);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample('1, 32'd1);
        send_sample(32'd1, '1);
        send_sample(32'h0001_0000, 32'h0001_0000);
        s_tvalid <= 1'b0;
        wait_results_drained();

        // no measurement noise, no time step: P00 collapses to zero, divisor zero
        load_config('0, '0, '0, '0);
        send_sample(32'h0010_0000, '0);
        send_sample(32'h0020_0000, '0);
        send_sample(32'hFFF0_0000, 32'h0005_0000);
        s_tvalid <= 1'b0;
        wait_results_drained();

        // largest period and noise terms
        load_config(DT_MAX, N_MAX, N_MAX, N_MAX);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample('0, '0);
        send_sample(32'h7FFF_0000, '1);
        s_tvalid <= 1'b0;
        wait_results_drained();

        // largest period with zero noise
        load_config(DT_MAX, '0, '0, '0);
        send_sample(S_MIN, S_MIN);
        send_sample(S_MAX, S_MAX);
        send_sample('0, 32'd1);
        s_tvalid <= 1'b0;
        wait_results_drained();

        // random phases, each with its own settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet = (ph == RANDOM_PHASES - 1);
            choose_config(plan[ph]);
            sim_bias = spread(5 << 16);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // receiver holds off while requests keep coming
                if (ph == 2 && n == 30) rx_hold_req = 1'b1;
                // sender pauses until the block has emptied
                if (ph == 4 && n == 50) begin
                    s_tvalid <= 1'b0;
                    wait_results_drained();
                end
                next_stimulus(ang, rt);
                send_sample(ang, rt);
            end
            s_tvalid <= 1'b0;
            wait_results_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/imu_kf_pkg.sv
rtl/core/imu_kf_mul.sv
rtl/core/imu_kf_div.sv
rtl/core/imu_kf_top.sv
sim/testbench.sv
